>>> rtl/core/wsmd_pkg.sv
// ----------------------------------------------------------------------------
// wsmd_pkg
// shared widths, codes and types of the windowed sensor mean deviation core
// ----------------------------------------------------------------------------
package wsmd_pkg;

  // channel layout: channel 0 is light, lanes 0.. of the deviation path are
  // mic, accel x, accel y, accel z
  localparam int CHANNELS  = 5;
  localparam int FRAC_BITS = 4;
  localparam int DEV_CH    = CHANNELS - 1;
  localparam int LANE_W    = (DEV_CH > 1) ? $clog2(DEV_CH) : 1;
  localparam int MIC_LANE  = 0;

  localparam int SAMPLE_W    = 16;
  localparam int TICK_W      = 10;
  localparam int LIMIT_W     = 16;
  localparam int LIMIT_RESET = 15000;

  localparam int DEV_W  = 40;
  localparam int RAW_W  = 34;
  localparam int MEAN_W = SAMPLE_W + 2 + FRAC_BITS;
  localparam int MAG_W  = MEAN_W + 1;
  localparam int OUT_W  = 20;
  localparam int CNT_W  = 16;
  localparam int TIME_W = 17;

  localparam int MIC_MAX     = 65535;
  localparam int ACC_MAX     = 32767;
  localparam int ACC_MIN_MAG = 32768;

  // divider: largest dividend is the light sum scaled up by the fraction
  localparam int DIV_W   = DEV_W + FRAC_BITS;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  // division jobs of one window close
  localparam int NJOBS          = 1 + 2 * DEV_CH;
  localparam int JOB_W          = $clog2(NJOBS);
  localparam int JOB_LIGHT      = 0;
  localparam int JOB_DEV_FIRST  = 1;
  localparam int JOB_MEAN_FIRST = 1 + DEV_CH;
  localparam int JOB_LAST       = NJOBS - 1;

  // stream payload widths
  localparam int IN_BITS     = TICK_W + CHANNELS * SAMPLE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = CHANNELS * OUT_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PUSH
  } ctrl_state_t;

  typedef struct packed {
    logic             capture;
    logic             accum;
    logic             div_start;
    logic             div_store;
    logic             load_out;
    logic [JOB_W-1:0] job;
  } dp_cmd_t;

  typedef struct packed {
    logic window_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // upper clamp of a stored mean, as a magnitude
  function automatic logic [DIV_W-1:0] mean_hi_mag(input logic [LANE_W-1:0] lane);
    if (lane == LANE_W'(MIC_LANE)) return DIV_W'(MIC_MAX) << FRAC_BITS;
    return DIV_W'(ACC_MAX) << FRAC_BITS;
  endfunction

  // lower clamp of a stored mean, as a magnitude of a negative value
  function automatic logic [DIV_W-1:0] mean_lo_mag(input logic [LANE_W-1:0] lane);
    if (lane == LANE_W'(MIC_LANE)) return '0;
    return DIV_W'(ACC_MIN_MAG) << FRAC_BITS;
  endfunction

endpackage

>>> rtl/core/wsmd_div.sv
// ----------------------------------------------------------------------------
// wsmd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wsmd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wsmd_pkg::DIV_W-1:0]  dividend,
  input  logic [wsmd_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [wsmd_pkg::DIV_W-1:0]  quotient
);

  logic [wsmd_pkg::DIV_W-1:0]  dq_r;
  logic [wsmd_pkg::CNT_W-1:0]  rem_r;
  logic [wsmd_pkg::CNT_W-1:0]  dvs_r;
  logic [wsmd_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [wsmd_pkg::CNT_W:0]    rem_sh;
  logic [wsmd_pkg::CNT_W:0]    rem_sub;
  logic                        fits;

  always_comb begin
    rem_sh  = {rem_r, dq_r[wsmd_pkg::DIV_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  // partial remainder stays below the divisor, so it fits CNT_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[wsmd_pkg::DIV_W-2:0], fits};
      rem_r <= fits ? rem_sub[wsmd_pkg::CNT_W-1:0] : rem_sh[wsmd_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= wsmd_pkg::DCNT_W'(wsmd_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - wsmd_pkg::DCNT_W'(1);
        if (cnt_r == wsmd_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> rtl/core/wsmd_datapath.sv
// ----------------------------------------------------------------------------
// wsmd_datapath
// window accumulators, mean store, shared divider and result register
// ----------------------------------------------------------------------------
module wsmd_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wsmd_pkg::dp_cmd_t                 cmd,
  output wsmd_pkg::dp_status_t              status,
  input  logic [wsmd_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              cfg_wr,
  input  logic [wsmd_pkg::LIMIT_W-1:0]      cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wsmd_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // captured item
  logic [wsmd_pkg::TICK_W-1:0]          tick_r;
  logic [wsmd_pkg::SAMPLE_W-1:0]        smp_r [wsmd_pkg::CHANNELS];

  // window state
  logic [wsmd_pkg::LIMIT_W-1:0]         limit_r;
  logic [wsmd_pkg::DEV_W-1:0]           light_sum_r;
  logic [wsmd_pkg::DEV_W-1:0]           dev_sum_r   [wsmd_pkg::DEV_CH];
  logic signed [wsmd_pkg::RAW_W-1:0]    raw_sum_r   [wsmd_pkg::DEV_CH];
  logic signed [wsmd_pkg::MEAN_W-1:0]   mean_r      [wsmd_pkg::DEV_CH];
  logic [wsmd_pkg::CNT_W-1:0]           count_r;
  logic [wsmd_pkg::TIME_W-1:0]          time_r;

  // staged results and output register
  logic [wsmd_pkg::OUT_W-1:0]           res_light_r;
  logic [wsmd_pkg::OUT_W-1:0]           res_dev_r [wsmd_pkg::DEV_CH];
  logic [wsmd_pkg::OUT_W-1:0]           out_light_r;
  logic [wsmd_pkg::OUT_W-1:0]           out_dev_r [wsmd_pkg::DEV_CH];
  logic [wsmd_pkg::CNT_W-1:0]           out_count_r;
  logic                                 out_valid_r;
  logic                                 job_neg_r;

  // accumulate lanes
  logic signed [wsmd_pkg::SAMPLE_W:0]   s_ext   [wsmd_pkg::DEV_CH];
  logic signed [wsmd_pkg::MAG_W-1:0]    diff    [wsmd_pkg::DEV_CH];
  logic [wsmd_pkg::MAG_W-1:0]           mag     [wsmd_pkg::DEV_CH];
  logic [wsmd_pkg::DEV_W:0]             dsum    [wsmd_pkg::DEV_CH];
  logic signed [wsmd_pkg::RAW_W:0]      rsum    [wsmd_pkg::DEV_CH];
  logic [wsmd_pkg::DEV_W-1:0]           dev_nxt [wsmd_pkg::DEV_CH];
  logic signed [wsmd_pkg::RAW_W-1:0]    raw_nxt [wsmd_pkg::DEV_CH];
  logic [wsmd_pkg::DEV_W:0]             lsum;
  logic [wsmd_pkg::DEV_W-1:0]           light_nxt;
  logic [wsmd_pkg::CNT_W-1:0]           count_nxt;
  logic [wsmd_pkg::TIME_W:0]            tsum;
  logic [wsmd_pkg::TIME_W-1:0]          time_nxt;

  // division jobs
  logic [wsmd_pkg::LANE_W-1:0]          dev_lane;
  logic [wsmd_pkg::LANE_W-1:0]          mean_lane;
  logic                                 is_light;
  logic                                 is_mean;
  logic signed [wsmd_pkg::RAW_W-1:0]    raw_sel;
  logic [wsmd_pkg::RAW_W-1:0]           raw_abs;
  logic [wsmd_pkg::DIV_W-1:0]           dividend;
  logic [wsmd_pkg::DIV_W-1:0]           quotient;
  logic                                 div_done;
  logic [wsmd_pkg::OUT_W-1:0]           q_clamp;
  logic [wsmd_pkg::DIV_W-1:0]           m_sel;
  logic [wsmd_pkg::MEAN_W-1:0]          m_mag;

  always_comb begin
    for (int i = 0; i < wsmd_pkg::DEV_CH; i++) begin
      if (i == wsmd_pkg::MIC_LANE) s_ext[i] = {1'b0, smp_r[i+1]};
      else s_ext[i] = {smp_r[i+1][wsmd_pkg::SAMPLE_W-1], smp_r[i+1]};
      diff[i] = (wsmd_pkg::MAG_W'(s_ext[i]) <<< wsmd_pkg::FRAC_BITS)
                - wsmd_pkg::MAG_W'(mean_r[i]);
      mag[i]  = diff[i][wsmd_pkg::MAG_W-1] ? wsmd_pkg::MAG_W'(-diff[i])
                                            : wsmd_pkg::MAG_W'(diff[i]);
      dsum[i] = {1'b0, dev_sum_r[i]} + (wsmd_pkg::DEV_W+1)'(mag[i]);
      dev_nxt[i] = dsum[i][wsmd_pkg::DEV_W] ? '1 : dsum[i][wsmd_pkg::DEV_W-1:0];
      rsum[i] = (wsmd_pkg::RAW_W+1)'(raw_sum_r[i]) + (wsmd_pkg::RAW_W+1)'(s_ext[i]);
      if (rsum[i][wsmd_pkg::RAW_W] != rsum[i][wsmd_pkg::RAW_W-1])
        raw_nxt[i] = rsum[i][wsmd_pkg::RAW_W] ? {1'b1, {(wsmd_pkg::RAW_W-1){1'b0}}}
                                              : {1'b0, {(wsmd_pkg::RAW_W-1){1'b1}}};
      else
        raw_nxt[i] = rsum[i][wsmd_pkg::RAW_W-1:0];
    end
    lsum      = {1'b0, light_sum_r} + (wsmd_pkg::DEV_W+1)'(smp_r[0]);
    light_nxt = lsum[wsmd_pkg::DEV_W] ? '1 : lsum[wsmd_pkg::DEV_W-1:0];
    count_nxt = (count_r == '1) ? count_r : count_r + wsmd_pkg::CNT_W'(1);
    tsum      = (wsmd_pkg::TIME_W+1)'(time_r) + (wsmd_pkg::TIME_W+1)'(tick_r);
    time_nxt  = tsum[wsmd_pkg::TIME_W] ? '1 : tsum[wsmd_pkg::TIME_W-1:0];
  end

  // operand select for the current job
  always_comb begin
    dev_lane  = wsmd_pkg::LANE_W'(cmd.job - wsmd_pkg::JOB_W'(wsmd_pkg::JOB_DEV_FIRST));
    mean_lane = wsmd_pkg::LANE_W'(cmd.job - wsmd_pkg::JOB_W'(wsmd_pkg::JOB_MEAN_FIRST));
    is_light  = cmd.job == wsmd_pkg::JOB_W'(wsmd_pkg::JOB_LIGHT);
    is_mean   = cmd.job >= wsmd_pkg::JOB_W'(wsmd_pkg::JOB_MEAN_FIRST);
    raw_sel   = raw_sum_r[mean_lane];
    raw_abs   = raw_sel[wsmd_pkg::RAW_W-1] ? wsmd_pkg::RAW_W'(-raw_sel)
                                           : wsmd_pkg::RAW_W'(raw_sel);
    if (is_light)
      dividend = wsmd_pkg::DIV_W'(light_sum_r) << wsmd_pkg::FRAC_BITS;
    else if (is_mean)
      dividend = wsmd_pkg::DIV_W'(raw_abs) << wsmd_pkg::FRAC_BITS;
    else
      dividend = wsmd_pkg::DIV_W'(dev_sum_r[dev_lane]);

    q_clamp = (|quotient[wsmd_pkg::DIV_W-1:wsmd_pkg::OUT_W]) ? '1
              : quotient[wsmd_pkg::OUT_W-1:0];
    if (job_neg_r)
      m_sel = (quotient > wsmd_pkg::mean_lo_mag(mean_lane))
              ? wsmd_pkg::mean_lo_mag(mean_lane) : quotient;
    else
      m_sel = (quotient > wsmd_pkg::mean_hi_mag(mean_lane))
              ? wsmd_pkg::mean_hi_mag(mean_lane) : quotient;
    m_mag = wsmd_pkg::MEAN_W'(m_sel);
  end

  wsmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // captured item, staged results, output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tick_r <= in_tdata[wsmd_pkg::TICK_W-1:0];
      for (int c = 0; c < wsmd_pkg::CHANNELS; c++)
        smp_r[c] <= in_tdata[wsmd_pkg::TICK_W + c*wsmd_pkg::SAMPLE_W +: wsmd_pkg::SAMPLE_W];
    end
    if (cmd.div_start)
      job_neg_r <= raw_sel[wsmd_pkg::RAW_W-1];
    if (cmd.div_store && !is_mean) begin
      if (is_light) res_light_r <= q_clamp;
      else res_dev_r[dev_lane] <= q_clamp;
    end
    if (cmd.load_out) begin
      out_light_r <= res_light_r;
      out_dev_r   <= res_dev_r;
      out_count_r <= count_r;
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= wsmd_pkg::LIMIT_W'(wsmd_pkg::LIMIT_RESET);
      light_sum_r <= '0;
      count_r     <= '0;
      time_r      <= '0;
      for (int i = 0; i < wsmd_pkg::DEV_CH; i++) begin
        dev_sum_r[i] <= '0;
        raw_sum_r[i] <= '0;
        mean_r[i]    <= '0;
      end
    end else begin
      if (cfg_wr) limit_r <= cfg_data;
      if (cmd.accum) begin
        light_sum_r <= light_nxt;
        dev_sum_r   <= dev_nxt;
        raw_sum_r   <= raw_nxt;
        count_r     <= count_nxt;
        time_r      <= time_nxt;
      end else if (cmd.load_out) begin
        light_sum_r <= '0;
        count_r     <= '0;
        time_r      <= '0;
        for (int i = 0; i < wsmd_pkg::DEV_CH; i++) begin
          dev_sum_r[i] <= '0;
          raw_sum_r[i] <= '0;
        end
      end
      if (cmd.div_store && is_mean)
        mean_r[mean_lane] <= job_neg_r ? -m_mag : m_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_comb begin
    out_tdata = '0;
    out_tdata[wsmd_pkg::OUT_W-1:0] = out_light_r;
    for (int i = 0; i < wsmd_pkg::DEV_CH; i++)
      out_tdata[wsmd_pkg::OUT_W*(i+1) +: wsmd_pkg::OUT_W] = out_dev_r[i];
    out_tdata[wsmd_pkg::CHANNELS*wsmd_pkg::OUT_W +: wsmd_pkg::CNT_W] = out_count_r;
  end

  assign out_tvalid         = out_valid_r;
  assign status.window_done = time_r >= wsmd_pkg::TIME_W'(limit_r);
  assign status.div_done    = div_done;
  assign status.out_free    = !out_valid_r || out_tready;

endmodule

>>> rtl/core/wsmd_ctrl.sv
// ----------------------------------------------------------------------------
// wsmd_ctrl
// sequencer: item intake, window check, division jobs, result hand-off
// ----------------------------------------------------------------------------
module wsmd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output wsmd_pkg::dp_cmd_t    cmd,
  input  wsmd_pkg::dp_status_t status
);

  wsmd_pkg::ctrl_state_t       state_r, state_nxt;
  logic [wsmd_pkg::JOB_W-1:0]  job_r, job_nxt;
  logic                        last_job;

  assign last_job = job_r == wsmd_pkg::JOB_W'(wsmd_pkg::JOB_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsmd_pkg::ST_IDLE;
      job_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    case (state_r)
      wsmd_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = wsmd_pkg::ST_ACCUM;
      end
      wsmd_pkg::ST_ACCUM: begin
        state_nxt = wsmd_pkg::ST_CHECK;
      end
      wsmd_pkg::ST_CHECK: begin
        if (status.window_done) begin
          state_nxt = wsmd_pkg::ST_DIV_START;
          job_nxt   = wsmd_pkg::JOB_W'(wsmd_pkg::JOB_LIGHT);
        end else begin
          state_nxt = wsmd_pkg::ST_IDLE;
        end
      end
      wsmd_pkg::ST_DIV_START: begin
        state_nxt = wsmd_pkg::ST_DIV_WAIT;
      end
      wsmd_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (last_job) begin
            state_nxt = wsmd_pkg::ST_PUSH;
          end else begin
            state_nxt = wsmd_pkg::ST_DIV_START;
            job_nxt   = job_r + wsmd_pkg::JOB_W'(1);
          end
        end
      end
      wsmd_pkg::ST_PUSH: begin
        if (status.out_free) state_nxt = wsmd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = wsmd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.job       = job_r;
    case (state_r)
      wsmd_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      wsmd_pkg::ST_ACCUM: begin
        cmd.accum = 1'b1;
      end
      wsmd_pkg::ST_DIV_START: begin
        cmd.div_start = 1'b1;
      end
      wsmd_pkg::ST_DIV_WAIT: begin
        cmd.div_store = status.div_done;
      end
      wsmd_pkg::ST_PUSH: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/windowed_sensor_mean_deviation_core.sv
// ----------------------------------------------------------------------------
// windowed_sensor_mean_deviation_core
// windowed light mean and mean absolute deviation of mic and accel channels
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------
//  in_     | in  | in_tvalid / in_tready    | in_tdata, 96 bits: one tick
//  out_    | out | out_tvalid / out_tready  | out_tdata, 120 bits: one window
//  cfg_    | in  | cfg_valid / cfg_ready    | cfg_data, 16 bits: window limit
//
//  a tick that does not close the window is taken, accumulated and
//  compared against the limit
//  a closing tick then runs 9 jobs on the one shared restoring divider,
//  each a load, 44 quotient bits and a store, and then loads the result
//  register once that register is free
//  reset is synchronous, active low; all sums, means, count and time clear
//  and the limit returns to 15000 ms, no clearing pass is needed
//  a result waiting in the output register does not stop new ticks; only
//  the next window close waits for that register to drain
//
module windowed_sensor_mean_deviation_core (
  input  logic                              clk,
  input  logic                              rst_n,

  // tick_ms [9:0], light_sample [25:10], mic_sample [41:26],
  // accel_x_sample [57:42], accel_y_sample [73:58], accel_z_sample [89:74],
  // zero [95:90]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wsmd_pkg::IN_TDATA_W-1:0]   in_tdata,

  // light_mean [19:0], mic_deviation [39:20], accel_x_deviation [59:40],
  // accel_y_deviation [79:60], accel_z_deviation [99:80],
  // window_samples [115:100], zero [119:116]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wsmd_pkg::OUT_TDATA_W-1:0]  out_tdata,

  // window_limit_ms
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsmd_pkg::LIMIT_W-1:0]      cfg_data
);

  wsmd_pkg::dp_cmd_t    cmd;
  wsmd_pkg::dp_status_t status;

  // the limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: one item at a time through intake, check and divisions
  wsmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .status    (status)
  );

  // sums, stored means, divider and the result register
  wsmd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/core/wsmd_checker.sv
// ----------------------------------------------------------------------------
// wsmd_checker
// port-level checks on the windowed sensor mean deviation core
// ----------------------------------------------------------------------------
module wsmd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [wsmd_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // one tick at a time: intake closes right after an item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken in back-to-back cycles");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // a closed window always holds at least one tick
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[wsmd_pkg::CHANNELS*wsmd_pkg::OUT_W +: wsmd_pkg::CNT_W] != '0)
    else $error("result with empty window");

  // a new result only follows a cycle in which intake was closed
  a_result_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while intake was open");

endmodule

bind windowed_sensor_mean_deviation_core wsmd_checker u_wsmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/windowed_sensor_mean_deviation_core_test.sv
// ----------------------------------------------------------------------------
// windowed_sensor_mean_deviation_core_test
// drives ticks into the core, predicts every closed window (light mean, four
// mean deviations, tick count) and compares each result item field by field
// ----------------------------------------------------------------------------
module windowed_sensor_mean_deviation_core_test;
  import wsmd_pkg::*;

  // longest quiet stretch allowed before the run is called hung
  localparam int QUIET_LIMIT = 20000;
  // receiver hold-off used to back the core up
  localparam int HOLD_CYCLES = 3000;
  // gap after the last result before a limit write, covers a non-closing tick
  localparam int SETTLE      = 24;
  // tail wait at the end, covers one full window close
  localparam int TAIL        = 450;

  localparam longint SCALE     = longint'(1) << FRAC_BITS;
  localparam longint DEV_TOP   = (longint'(1) << DEV_W) - 1;
  localparam longint RAW_TOP   = (longint'(1) << (RAW_W - 1)) - 1;
  localparam longint RAW_BOT   = -(longint'(1) << (RAW_W - 1));
  localparam longint OUT_TOP   = (longint'(1) << OUT_W) - 1;
  localparam longint COUNT_TOP = (longint'(1) << CNT_W) - 1;
  localparam longint TIME_TOP  = (longint'(1) << TIME_W) - 1;

  // idling patterns of the two stream sides
  typedef enum int {
    PACE_LAZY_SINK,    // sender idles 28 %, receiver 56 %
    PACE_LAZY_SOURCE,  // sender idles 56 %, receiver 28 %
    PACE_FULL          // nobody idles
  } pace_t;

  typedef struct {
    logic [TICK_W-1:0]          tick_ms;
    logic [SAMPLE_W-1:0]        light;
    logic [SAMPLE_W-1:0]        mic;
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] ay;
    logic signed [SAMPLE_W-1:0] az;
  } tick_t;

  typedef struct {
    logic [OUT_W-1:0] light_mean;
    logic [OUT_W-1:0] deviation [DEV_CH];
    logic [CNT_W-1:0] samples;
  } window_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [LIMIT_W-1:0]     cfg_data   = '0;

  always #1 clk = ~clk;

  windowed_sensor_mean_deviation_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // ticks waiting to be offered, windows waiting to come out
  tick_t   tick_queue [$];
  window_t window_results [$];
  tick_t   cur_tick;

  // mirror of the core's state, at the core's widths
  logic [DEV_W-1:0]         dev_acc   [CHANNELS];
  logic signed [RAW_W-1:0]  raw_acc   [DEV_CH];
  logic signed [MEAN_W-1:0] last_mean [DEV_CH];
  logic [CNT_W-1:0]         tick_count;
  logic [TIME_W-1:0]        elapsed_ms;
  logic [LIMIT_W-1:0]       limit_ms;

  pace_t pace          = PACE_LAZY_SINK;
  int    hold_asks     = 0;
  int    hold_served   = 0;
  int    hold_left     = 0;
  int    quiet_cycles  = 0;
  int    errors        = 0;
  int    ticks_in      = 0;
  int    windows_seen  = 0;
  int    limit_writes  = 0;

  string lane_name [DEV_CH] = '{"mic_deviation", "accel_x_deviation",
                                "accel_y_deviation", "accel_z_deviation"};

  function automatic logic [OUT_W-1:0] clip_out(input longint v);
    return OUT_W'(v > OUT_TOP ? OUT_TOP : v);
  endfunction

  // one tick into the mirror; a closing tick queues the window it emits
  function automatic void tally_tick(input tick_t t);
    longint  smp [DEV_CH];
    longint  sum, dif, n, m, lo, hi;
    window_t w;
    smp[0] = longint'(t.mic);
    smp[1] = longint'(t.ax);
    smp[2] = longint'(t.ay);
    smp[3] = longint'(t.az);

    // light is summed raw in slot 0
    sum = longint'(dev_acc[0]) + longint'(t.light);
    dev_acc[0] = DEV_W'(sum > DEV_TOP ? DEV_TOP : sum);
    for (int c = 0; c < DEV_CH; c++) begin
      // distance from last window's mean, in fractional units
      dif = smp[c] * SCALE - longint'(last_mean[c]);
      if (dif < 0) dif = -dif;
      sum = longint'(dev_acc[c + 1]) + dif;
      dev_acc[c + 1] = DEV_W'(sum > DEV_TOP ? DEV_TOP : sum);
      sum = longint'(raw_acc[c]) + smp[c];
      if (sum > RAW_TOP) sum = RAW_TOP;
      if (sum < RAW_BOT) sum = RAW_BOT;
      raw_acc[c] = RAW_W'(sum);
    end
    if (longint'(tick_count) != COUNT_TOP) tick_count = tick_count + 1'b1;
    sum = longint'(elapsed_ms) + longint'(t.tick_ms);
    elapsed_ms = TIME_W'(sum > TIME_TOP ? TIME_TOP : sum);

    if (elapsed_ms < limit_ms) return;

    // window closes
    n = longint'(tick_count);
    w.light_mean = clip_out((longint'(dev_acc[0]) << FRAC_BITS) / n);
    for (int c = 0; c < DEV_CH; c++) begin
      lo = (c == MIC_LANE) ? 0 : -longint'(ACC_MIN_MAG) * SCALE;
      hi = (c == MIC_LANE) ? longint'(MIC_MAX) * SCALE : longint'(ACC_MAX) * SCALE;
      // signed division truncates toward zero
      m = (longint'(raw_acc[c]) * SCALE) / n;
      if (m < lo) m = lo;
      if (m > hi) m = hi;
      last_mean[c] = MEAN_W'(m);
      w.deviation[c] = clip_out(longint'(dev_acc[c + 1]) / n);
    end
    w.samples = tick_count;
    window_results.push_back(w);

    foreach (dev_acc[i]) dev_acc[i] = '0;
    foreach (raw_acc[i]) raw_acc[i] = '0;
    tick_count = '0;
    elapsed_ms = '0;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_tick(input tick_t t);
    return IN_TDATA_W'({t.az, t.ay, t.ax, t.mic, t.light, t.tick_ms});
  endfunction

  function automatic tick_t make_tick(input int ms, input logic [15:0] light,
                                      input logic [15:0] mic, input logic [15:0] ax,
                                      input logic [15:0] ay, input logic [15:0] az);
    tick_t t;
    t.tick_ms = TICK_W'(ms);
    t.light   = light;
    t.mic     = mic;
    t.ax      = ax;
    t.ay      = ay;
    t.az      = az;
    return t;
  endfunction

  // raw sample bits, leaning on the unsigned and signed extremes
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic tick_t random_tick();
    int ms;
    case ($urandom_range(9))
      0:       ms = 0;
      1:       ms = 1023;
      2:       ms = 1000;
      default: ms = $urandom_range(1023);
    endcase
    return make_tick(ms, rand_sample(), rand_sample(), rand_sample(),
                     rand_sample(), rand_sample());
  endfunction

  function automatic bit sender_pause();
    case (pace)
      PACE_LAZY_SINK:   return $urandom_range(99) < 28;
      PACE_LAZY_SOURCE: return $urandom_range(99) < 56;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_pause();
    case (pace)
      PACE_LAZY_SINK:   return $urandom_range(99) < 56;
      PACE_LAZY_SOURCE: return $urandom_range(99) < 28;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string what, input longint want,
                                      input longint got);
    if (want != got) begin
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers ticks from the queue, holds an item until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    if (in_tvalid && in_tready) begin
      tally_tick(cur_tick);
      ticks_in++;
    end
    if (in_tvalid && !in_tready) begin
      // item still on offer, keep it steady
    end else if (rst_n && tick_queue.size() != 0 && !sender_pause()) begin
      cur_tick = tick_queue.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= pack_tick(cur_tick);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each window item against the oldest prediction and
  // paces out_tready, with an occasional long hold-off to back the core up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    window_t                want;
    logic [OUT_TDATA_W-1:0] d;
    logic                   rdy;
    if (out_tvalid && out_tready) begin
      d = out_tdata;
      if (window_results.size() == 0) begin
        errors++;
        $display("%0t: window item not expected, expected none, actual %h", $time, d);
      end else begin
        want = window_results.pop_front();
        check_field("light_mean", want.light_mean, d[0 +: OUT_W]);
        for (int c = 0; c < DEV_CH; c++)
          check_field(lane_name[c], want.deviation[c], d[(c + 1) * OUT_W +: OUT_W]);
        check_field("window_samples", want.samples, d[CHANNELS * OUT_W +: CNT_W]);
        windows_seen++;
      end
    end

    if (!rst_n) begin
      rdy = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
      rdy = 1'b0;
    end else begin
      rdy = !receiver_pause();
    end
    out_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // watchdog: any handshake on any channel counts as progress
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d windows still pending",
               $time, QUIET_LIMIT, window_results.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // wait until every tick is taken and every window has come out; sampled
  // mid-cycle so the driver's updates of the last edge are all visible
  task automatic drain();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_tvalid || window_results.size() != 0);
    // a tick that closes nothing may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    limit_ms = v;
    limit_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int count,
                           input pace_t p, input bit squeeze);
    pace = p;
    set_window_limit(lim);
    if (squeeze) hold_asks++;
    repeat (count) tick_queue.push_back(random_tick());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    tick_t t;
    foreach (dev_acc[i]) dev_acc[i] = '0;
    foreach (raw_acc[i]) raw_acc[i] = '0;
    foreach (last_mean[i]) last_mean[i] = '0;
    tick_count = '0;
    elapsed_ms = '0;
    limit_ms   = LIMIT_W'(LIMIT_RESET);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset limit, first window measured against zero means,
    // samples swinging between opposite extremes
    tick_queue.push_back(make_tick(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    for (int i = 0; i < 15; i++) begin
      if (i % 2 == 0)
        t = make_tick(i == 0 ? 1000 : 1023, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000,
                      16'h7FFF);
      else
        t = make_tick(1023, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
      tick_queue.push_back(t);
    end
    drain();

    // zero limit: every tick closes its own window
    set_window_limit('0);
    tick_queue.push_back(make_tick(5, 16'h04D2, 16'hFFFF, 16'h8000, 16'h0000, 16'h7FFF));
    tick_queue.push_back(make_tick(0, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000));
    tick_queue.push_back(make_tick(1023, 16'h8000, 16'h8000, 16'h0001, 16'hFFFF, 16'h8001));
    drain();

    // smallest nonzero limit: a zero-ms tick stays open, a one-ms tick closes
    set_window_limit(LIMIT_W'(1));
    tick_queue.push_back(make_tick(0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h1234));
    tick_queue.push_back(make_tick(1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hEDCB));
    drain();

    // random phases under varying limits and idling
    run_phase(LIMIT_W'(2000), 150, PACE_LAZY_SINK, 1'b0);
    run_phase('0, 60, PACE_LAZY_SINK, 1'b1);
    run_phase(LIMIT_W'(65535), 200, PACE_LAZY_SOURCE, 1'b0);
    run_phase(LIMIT_W'(300), 120, PACE_LAZY_SOURCE, 1'b0);
    run_phase(LIMIT_W'($urandom_range(8000, 1)), 150, PACE_LAZY_SOURCE, 1'b0);
    run_phase(LIMIT_W'(1), 80, PACE_FULL, 1'b0);
    run_phase(LIMIT_W'(5000), 160, PACE_FULL, 1'b0);

    // pin the means: first tick flushes the open window, second sets them
    set_window_limit(LIMIT_W'(1));
    repeat (2) tick_queue.push_back(make_tick(1, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF,
                                              16'h0000));
    drain();

    // random ticks under a one-ms limit, the first window measured against the pinned means
    run_phase(LIMIT_W'(1), 10, PACE_FULL, 1'b0);

    repeat (TAIL) @(posedge clk);

    $display("run covered %0d ticks and %0d closed windows over %0d limit settings,",
             ticks_in, windows_seen, limit_writes);
    $display("including zero and maximum limits, over-range ticks and a long output stall");
    if (errors == 0 && window_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d windows never seen", errors, window_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/wsmd_pkg.sv
rtl/core/wsmd_div.sv
rtl/core/wsmd_datapath.sv
rtl/core/wsmd_ctrl.sv
rtl/core/windowed_sensor_mean_deviation_core.sv
rtl/core/wsmd_checker.sv
tb/windowed_sensor_mean_deviation_core_test.sv
